FILE: rtl/pfe_pkg.sv
// Shared types, constants and helpers for the Playfair digraph encryptor.
package pfe_pkg;

   localparam int LETTER_W  = 5;
   localparam int ALPHABET  = 26;
   localparam int CELLS     = 25;
   localparam int SIDE      = 5;
   localparam int KEY_BITS  = CELLS * LETTER_W;
   localparam int REG_A_W   = 45;
   localparam int REG_B_W   = 45;
   localparam int REG_C_W   = 35;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [CELLS-1:0][LETTER_W-1:0] square_type;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;

   typedef enum logic [1:0] {
      REG_KEY_A   = 2'd0,
      REG_KEY_B   = 2'd1,
      REG_KEY_C   = 2'd2,
      REG_KEY_LEN = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      BLD_START,
      BLD_KEY,
      BLD_FILL,
      BLD_DONE
   } build_state_type;

   // configuration as seen by the square builder
   typedef struct packed {
      logic                  wr;
      logic [LETTER_W-1:0]   key_length;
      logic [KEY_BITS-1:0]   key_bits;
   } csr_cfg_type;

   typedef struct packed {
      logic ready;
      logic key_bad;
   } square_status_type;

   function automatic letter_type fold_j(letter_type l);
      return (l == LETTER_J) ? LETTER_I : l;
   endfunction

endpackage

FILE: rtl/playfair_digraph_encrypt_top.sv
// Top level of the Playfair digraph encryptor.
// Encrypts one letter pair (A=0 .. Z=25) per transaction with a 5x5 key square.
// After reset and after every register write the square is rebuilt by a
// sequencer that places one letter per cycle; req_stall stays high until it
// is done. Once built, a pair is accepted every cycle unless rsp_stall backs
// up the result register; the lookup is a parallel compare against all 25
// square cells between the input and result registers.
// Write the key registers only while no transaction is in flight.
module playfair_digraph_encrypt_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pfe_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [pfe_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [pfe_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [4:0]                      req_first_letter,
   input  logic [4:0]                      req_second_letter,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [4:0]                      rsp_cipher_first,
   output logic [4:0]                      rsp_cipher_second,
   output logic                            rsp_pair_error,
   output logic                            rsp_key_error
);
   import pfe_pkg::*;

   csr_cfg_type        cfg;
   square_type         square;
   square_status_type  status;

   pfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pfe_square_build u_build (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .square (square),
      .status (status)
   );

   pfe_cipher u_cipher (
      .clock             (clock),
      .reset             (reset),
      .square            (square),
      .status            (status),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_first_letter  (req_first_letter),
      .req_second_letter (req_second_letter),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cipher_first  (rsp_cipher_first),
      .rsp_cipher_second (rsp_cipher_second),
      .rsp_pair_error    (rsp_pair_error),
      .rsp_key_error     (rsp_key_error)
   );

endmodule

FILE: rtl/pfe_csr.sv
// Configuration register file with an APB-style access port.
module pfe_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pfe_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [pfe_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [pfe_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output pfe_pkg::csr_cfg_type            cfg
);
   import pfe_pkg::*;

   logic [REG_A_W-1:0]  key_a_ff;
   logic [REG_B_W-1:0]  key_b_ff;
   logic [REG_C_W-1:0]  key_c_ff;
   letter_type          key_len_ff;
   logic                wr_en;
   reg_index_type       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = reg_index_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_a_ff   <= '0;
         key_b_ff   <= '0;
         key_c_ff   <= '0;
         key_len_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_KEY_A:   key_a_ff   <= pwdata[REG_A_W-1:0];
            REG_KEY_B:   key_b_ff   <= pwdata[REG_B_W-1:0];
            REG_KEY_C:   key_c_ff   <= pwdata[REG_C_W-1:0];
            REG_KEY_LEN: key_len_ff <= pwdata[LETTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_KEY_A:   prdata = CSR_DATA_W'(key_a_ff);
         REG_KEY_B:   prdata = CSR_DATA_W'(key_b_ff);
         REG_KEY_C:   prdata = CSR_DATA_W'(key_c_ff);
         REG_KEY_LEN: prdata = CSR_DATA_W'(key_len_ff);
         default:     prdata = '0;
      endcase
   end

   assign cfg.wr         = wr_en;
   assign cfg.key_length = key_len_ff;
   assign cfg.key_bits   = {key_c_ff, key_b_ff, key_a_ff};

endmodule

FILE: rtl/pfe_square_build.sv
// Sequencer that builds the 5x5 key square one letter per cycle.
module pfe_square_build (
   input  logic                       clock,
   input  logic                       reset,
   input  pfe_pkg::csr_cfg_type       cfg,
   output pfe_pkg::square_type        square,
   output pfe_pkg::square_status_type status
);
   import pfe_pkg::*;

   build_state_type        state_ff, state_in;
   logic [KEY_BITS-1:0]    shift_ff, shift_in;
   letter_type             idx_ff, idx_in;
   letter_type             cells_ff, cells_in;
   logic [ALPHABET-1:0]    used_ff, used_in;
   logic                   key_bad_ff, key_bad_in;
   square_type             square_ff;
   logic                   sq_we;
   letter_type             sq_addr;
   letter_type             sq_data;
   letter_type             len_cap;
   letter_type             cur;
   letter_type             cur_fold;

   assign len_cap  = (cfg.key_length > 5'(CELLS)) ? 5'(CELLS) : cfg.key_length;
   assign cur      = shift_ff[LETTER_W-1:0];
   assign cur_fold = fold_j(cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BLD_START;
         idx_ff     <= '0;
         cells_ff   <= '0;
         used_ff    <= '0;
         key_bad_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cells_ff   <= cells_in;
         used_ff    <= used_in;
         key_bad_ff <= key_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (sq_we) begin
         square_ff[sq_addr] <= sq_data;
      end
   end

   always_comb begin
      state_in   = state_ff;
      shift_in   = shift_ff;
      idx_in     = idx_ff;
      cells_in   = cells_ff;
      used_in    = used_ff;
      key_bad_in = key_bad_ff;
      sq_we      = 1'b0;
      sq_addr    = cells_ff;
      sq_data    = cur_fold;
      unique case (state_ff)
         BLD_START: begin
            shift_in   = cfg.key_bits;
            idx_in     = '0;
            cells_in   = '0;
            used_in    = '0;
            key_bad_in = (cfg.key_length > 5'(CELLS));
            state_in   = BLD_KEY;
         end
         BLD_KEY: begin
            if (idx_ff == len_cap) begin
               idx_in   = '0;
               state_in = BLD_FILL;
            end else begin
               // letters above Z are flagged and skipped
               if (cur >= 5'(ALPHABET)) begin
                  key_bad_in = 1'b1;
               end else begin
                  if (used_ff[cur_fold]) begin
                     key_bad_in = 1'b1;
                  end
                  used_in[cur_fold] = 1'b1;
                  if (cells_ff < 5'(CELLS)) begin
                     sq_we    = 1'b1;
                     cells_in = cells_ff + 5'd1;
                  end
               end
               shift_in = shift_ff >> LETTER_W;
               idx_in   = idx_ff + 5'd1;
            end
         end
         BLD_FILL: begin
            sq_data = idx_ff;
            if (idx_ff != LETTER_J && !used_ff[idx_ff] && cells_ff < 5'(CELLS)) begin
               sq_we    = 1'b1;
               cells_in = cells_ff + 5'd1;
            end
            if (idx_ff == 5'(ALPHABET - 1)) begin
               state_in = BLD_DONE;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         BLD_DONE: ;
         default: state_in = BLD_START;
      endcase
      // any register write restarts the build
      if (cfg.wr) begin
         state_in = BLD_START;
      end
   end

   assign square         = square_ff;
   assign status.ready   = (state_ff == BLD_DONE);
   assign status.key_bad = key_bad_ff;

endmodule

FILE: rtl/pfe_cipher.sv
// Two-register encryption datapath: input register, cell match logic, result register.
module pfe_cipher (
   input  logic                       clock,
   input  logic                       reset,
   input  pfe_pkg::square_type        square,
   input  pfe_pkg::square_status_type status,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pfe_pkg::letter_type        req_first_letter,
   input  pfe_pkg::letter_type        req_second_letter,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pfe_pkg::letter_type        rsp_cipher_first,
   output pfe_pkg::letter_type        rsp_cipher_second,
   output logic                       rsp_pair_error,
   output logic                       rsp_key_error
);
   import pfe_pkg::*;

   logic              s1_valid_ff;
   letter_type        s1_first_ff;
   letter_type        s1_second_ff;
   logic              rsp_valid_ff;
   letter_type        c1_ff, c1_in;
   letter_type        c2_ff, c2_in;
   logic              pair_err_ff, pair_err_in;
   logic              key_err_ff;
   logic              s2_open;
   logic              s1_move;
   logic              req_take;
   letter_type        p_fold;
   letter_type        q_fold;
   logic [CELLS-1:0]  m1, m2;
   logic [SIDE-1:0]   r1, r2, k1, k2;
   logic              same_row, same_col;
   logic [CELLS-1:0]  sel1, sel2;
   letter_type        pick1, pick2;

   assign s2_open   = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_open;
   assign req_stall = !status.ready || (s1_valid_ff && !s2_open);
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (s2_open) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_first_ff  <= req_first_letter;
         s1_second_ff <= req_second_letter;
      end
      if (s1_move) begin
         c1_ff       <= c1_in;
         c2_ff       <= c2_in;
         pair_err_ff <= pair_err_in;
         key_err_ff  <= status.key_bad;
      end
   end

   assign p_fold = fold_j(s1_first_ff);
   assign q_fold = fold_j(s1_second_ff);
   assign pair_err_in = (s1_first_ff >= 5'(ALPHABET)) || (s1_second_ff >= 5'(ALPHABET))
                        || (p_fold == q_fold);

   // one-hot cell match, then row and column of each letter
   for (genvar i = 0; i < CELLS; i++) begin : g_match
      assign m1[i] = (square[i] == p_fold);
      assign m2[i] = (square[i] == q_fold);
   end

   for (genvar r = 0; r < SIDE; r++) begin : g_rowcol
      assign r1[r] = |m1[r*SIDE +: SIDE];
      assign r2[r] = |m2[r*SIDE +: SIDE];
      always_comb begin
         k1[r] = 1'b0;
         k2[r] = 1'b0;
         for (int j = 0; j < SIDE; j++) begin
            k1[r] = k1[r] | m1[j*SIDE + r];
            k2[r] = k2[r] | m2[j*SIDE + r];
         end
      end
   end

   assign same_row = |(r1 & r2);
   assign same_col = |(k1 & k2);

   for (genvar r = 0; r < SIDE; r++) begin : g_sel_row
      for (genvar c = 0; c < SIDE; c++) begin : g_sel_col
         localparam int CP = (c + SIDE - 1) % SIDE;
         localparam int RP = (r + SIDE - 1) % SIDE;
         assign sel1[r*SIDE + c] = same_row ? (r1[r] & k1[CP]) :
                                   same_col ? (r1[RP] & k1[c]) : (r1[r] & k2[c]);
         assign sel2[r*SIDE + c] = same_row ? (r2[r] & k2[CP]) :
                                   same_col ? (r2[RP] & k2[c]) : (r2[r] & k1[c]);
      end
   end

   always_comb begin
      pick1 = '0;
      pick2 = '0;
      for (int i = 0; i < CELLS; i++) begin
         pick1 = pick1 | (sel1[i] ? square[i] : '0);
         pick2 = pick2 | (sel2[i] ? square[i] : '0);
      end
      // drop the letters on any error
      if (pair_err_in || status.key_bad) begin
         c1_in = '0;
         c2_in = '0;
      end else begin
         c1_in = pick1;
         c2_in = pick2;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cipher_first  = c1_ff;
   assign rsp_cipher_second = c2_ff;
   assign rsp_pair_error    = pair_err_ff;
   assign rsp_key_error     = key_err_ff;

   a_no_j_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (c1_ff != LETTER_J && c2_ff != LETTER_J))
      else $error("cipher letter J on output");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (pair_err_ff || key_err_ff)) |-> (c1_ff == '0 && c2_ff == '0))
      else $error("nonzero cipher letters with an error flag");

   a_distinct: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !pair_err_ff && !key_err_ff) |-> (c1_ff != c2_ff))
      else $error("equal cipher letters for a valid pair");

   a_build_idle: assert property (@(posedge clock) disable iff (reset)
      (!status.ready && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("pair accepted while the square is not ready");

endmodule

FILE: tb/playfair_digraph_encrypt_top_tb.sv
// Self-checking testbench for the Playfair digraph encryptor: directed and random pairs.
class playfair_scoreboard;
   typedef struct packed {
      pfe_pkg::letter_type cipher_first;
      pfe_pkg::letter_type cipher_second;
      logic                pair_error;
      logic                key_error;
   } cipher_type;

   logic [44:0]         key_a;
   logic [44:0]         key_b;
   logic [34:0]         key_c;
   logic [4:0]          key_len;
   pfe_pkg::letter_type square [25];
   bit                  square_built;
   bit                  key_invalid;
   cipher_type          expected_ciphers [$];
   int                  mismatches;
   int                  checked;
   int                  pair_errors;
   int                  key_errors;

   function new();
      key_a = '0;
      key_b = '0;
      key_c = '0;
      key_len = '0;
      square_built = 1'b0;
      key_invalid = 1'b0;
      mismatches = 0;
      checked = 0;
      pair_errors = 0;
      key_errors = 0;
   endfunction

   task report_mismatch(string field, int got, int want);
      $display("%t MISMATCH %s: got %0d, want %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   function void write_reg(pfe_pkg::reg_index_type idx, logic [63:0] value);
      case (idx)
         pfe_pkg::REG_KEY_A:   key_a = value[44:0];
         pfe_pkg::REG_KEY_B:   key_b = value[44:0];
         pfe_pkg::REG_KEY_C:   key_c = value[34:0];
         pfe_pkg::REG_KEY_LEN: key_len = value[4:0];
         default: ;
      endcase
      square_built = 1'b0;
   endfunction

   function pfe_pkg::letter_type merge_ij(pfe_pkg::letter_type l);
      return (l == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : l;
   endfunction

   function pfe_pkg::letter_type key_letter(int i);
      if (i < 9) return key_a[5*i +: 5];
      if (i < 18) return key_b[5*(i-9) +: 5];
      return key_c[5*(i-18) +: 5];
   endfunction

   function void build_square();
      bit                  taken [26];
      int                  cells;
      int                  len;
      pfe_pkg::letter_type l;
      foreach (taken[i]) taken[i] = 1'b0;
      cells = 0;
      len = int'(key_len);
      key_invalid = 1'b0;
      if (len > 25) begin
         key_invalid = 1'b1;
         len = 25;
      end
      for (int i = 0; i < len; i++) begin
         l = key_letter(i);
         if (l >= 5'd26) begin
            key_invalid = 1'b1;
         end else begin
            l = merge_ij(l);
            if (taken[l]) key_invalid = 1'b1;
            taken[l] = 1'b1;
            if (cells < 25) begin
               square[cells] = l;
               cells++;
            end
         end
      end
      for (int i = 0; i < 26; i++) begin
         if (i != int'(pfe_pkg::LETTER_J) && !taken[i] && cells < 25) begin
            square[cells] = 5'(i);
            cells++;
         end
      end
      while (cells < 25) begin
         square[cells] = '0;
         cells++;
      end
      square_built = 1'b1;
   endfunction

   function int find_cell(pfe_pkg::letter_type l);
      for (int i = 0; i < 25; i++)
         if (square[i] == l) return i;
      return 0;
   endfunction

   function void note_pair(pfe_pkg::letter_type p, pfe_pkg::letter_type q);
      cipher_type want;
      int         a, b, r1, k1, r2, k2;
      if (!square_built) build_square();
      want = '0;
      want.pair_error = (p >= 5'd26) || (q >= 5'd26) || (merge_ij(p) == merge_ij(q));
      want.key_error = key_invalid;
      if (!want.pair_error && !key_invalid) begin
         a = find_cell(merge_ij(p));
         b = find_cell(merge_ij(q));
         r1 = a / 5;
         k1 = a % 5;
         r2 = b / 5;
         k2 = b % 5;
         if (r1 == r2) begin
            want.cipher_first = square[r1*5 + (k1+1) % 5];
            want.cipher_second = square[r2*5 + (k2+1) % 5];
         end else if (k1 == k2) begin
            want.cipher_first = square[((r1+1) % 5)*5 + k1];
            want.cipher_second = square[((r2+1) % 5)*5 + k2];
         end else begin
            want.cipher_first = square[r1*5 + k2];
            want.cipher_second = square[r2*5 + k1];
         end
      end
      expected_ciphers.push_back(want);
   endfunction

   task check_cipher(logic [4:0] c1, logic [4:0] c2, logic pe, logic ke);
      cipher_type want;
      if (expected_ciphers.size() == 0) begin
         report_mismatch("unexpected transaction, cipher_first", int'(c1), 0);
      end else begin
         want = expected_ciphers.pop_front();
         checked++;
         if (want.pair_error) pair_errors++;
         if (want.key_error) key_errors++;
         if (c1 !== want.cipher_first)
            report_mismatch("cipher_first", int'(c1), int'(want.cipher_first));
         if (c2 !== want.cipher_second)
            report_mismatch("cipher_second", int'(c2), int'(want.cipher_second));
         if (pe !== want.pair_error)
            report_mismatch("pair_error", int'(pe), int'(want.pair_error));
         if (ke !== want.key_error)
            report_mismatch("key_error", int'(ke), int'(want.key_error));
      end
   endtask
endclass

module playfair_digraph_encrypt_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pfe_pkg::*;

   localparam int IDLE_PERCENT = 10;
   localparam int QUIET_LIMIT = 5000;
   localparam int RANDOM_PHASES = 12;
   localparam int PAIRS_PER_PHASE = 50;
   localparam byte ASCII_A = 8'd65;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  req_valid;
   logic                  req_stall;
   logic [4:0]            req_first_letter;
   logic [4:0]            req_second_letter;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [4:0]            rsp_cipher_first;
   logic [4:0]            rsp_cipher_second;
   logic                  rsp_pair_error;
   logic                  rsp_key_error;

   playfair_scoreboard sb = new();
   bit                 calm;
   int                 keys_loaded;
   int                 quiet_cycles;

   playfair_digraph_encrypt_top u_top (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_first_letter  (req_first_letter),
      .req_second_letter (req_second_letter),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cipher_first  (rsp_cipher_first),
      .rsp_cipher_second (rsp_cipher_second),
      .rsp_pair_error    (rsp_pair_error),
      .rsp_key_error     (rsp_key_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // pack a word of capital letters into key register bits
   function automatic logic [124:0] word_key(string w);
      logic [124:0] bits;
      bits = '0;
      for (int i = 0; i < w.len() && i < 25; i++)
         bits[5*i +: 5] = 5'(w[i] - ASCII_A);
      return bits;
   endfunction

   task send_pair(letter_type p, letter_type q);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_first_letter <= p;
      req_second_letter <= q;
      do @(posedge clock); while (req_stall);
      sb.note_pair(p, q);
      @(negedge clock);
   endtask

   task write_reg(reg_index_type idx, logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // hold the bus idle before the next access
      @(negedge clock);
   endtask

   // hold until every cipher is back, then let the pipeline settle
   task wait_for_ciphers();
      req_valid <= 1'b0;
      while (sb.expected_ciphers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task load_key(logic [124:0] letters, logic [4:0] len, bit junk_upper);
      logic [63:0] upper;
      upper = junk_upper ? {$urandom, $urandom} : 64'd0;
      write_reg(REG_KEY_A, {upper[63:45], letters[44:0]});
      write_reg(REG_KEY_B, {upper[63:45], letters[89:45]});
      write_reg(REG_KEY_C, {upper[63:35], letters[124:90]});
      write_reg(REG_KEY_LEN, {upper[63:5], len});
      keys_loaded++;
   endtask

   task random_key();
      letter_type   pool [25];
      letter_type   t;
      logic [127:0] noise;
      logic [124:0] bits;
      int           k, j, len, kind, pos;
      k = 0;
      for (int l = 0; l < 26; l++) begin
         if (l != int'(LETTER_J)) begin
            pool[k] = 5'(l);
            k++;
         end
      end
      for (int i = 24; i > 0; i--) begin
         j = int'($urandom_range(i));
         t = pool[i];
         pool[i] = pool[j];
         pool[j] = t;
      end
      noise = {$urandom, $urandom, $urandom, $urandom};
      bits = noise[124:0];
      kind = int'($urandom_range(9));
      case (kind)
         2: len = 25;
         3: len = 0;
         default: len = int'($urandom_range(25));
      endcase
      for (int i = 0; i < len; i++) begin
         bits[5*i +: 5] = pool[i];
         if (pool[i] == LETTER_I && $urandom_range(1) == 1) bits[5*i +: 5] = LETTER_J;
      end
      if (kind == 0) begin
         // repeat one key letter
         if (len < 2) len = 2 + int'($urandom_range(23));
         for (int i = 0; i < len; i++) bits[5*i +: 5] = pool[i];
         pos = int'($urandom_range(len - 1, 1));
         bits[5*pos +: 5] = bits[5*int'($urandom_range(pos - 1)) +: 5];
      end else if (kind == 1) begin
         if ($urandom_range(1) == 1) begin
            if (len < 1) len = 1;
            bits[5*int'($urandom_range(len - 1)) +: 5] = 5'($urandom_range(31, 26));
         end else begin
            len = int'($urandom_range(31, 26));
         end
      end
      load_key(bits, 5'(len), $urandom_range(1) == 1);
   endtask

   task random_pair();
      letter_type p, q;
      if ($urandom_range(99) < 15) begin
         p = 5'($urandom_range(31));
         q = 5'($urandom_range(31));
      end else begin
         p = 5'($urandom_range(25));
         do q = 5'($urandom_range(25));
         while (sb.merge_ij(q) == sb.merge_ij(p));
      end
      send_pair(p, q);
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_valid = 1'b0;
      req_first_letter = '0;
      req_second_letter = '0;
      calm = 1'b0;
      keys_loaded = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty key after reset: plain alphabet square
      send_pair(5'd0, 5'd1);
      send_pair(5'd0, 5'd5);
      send_pair(5'd0, 5'd6);
      send_pair(5'd4, 5'd0);
      send_pair(5'd20, 5'd0);
      send_pair(5'd23, 5'd24);
      send_pair(5'd9, 5'd10);
      send_pair(5'd25, 5'd23);
      send_pair(5'd8, 5'd9);
      send_pair(5'd0, 5'd0);
      send_pair(5'd26, 5'd1);
      send_pair(5'd1, 5'd31);
      wait_for_ciphers();

      load_key(word_key("PLAYFIREXM"), 5'd10, 1'b1);
      send_pair(5'd7, 5'd4);
      send_pair(5'd15, 5'd11);
      send_pair(5'd24, 5'd25);
      send_pair(5'd12, 5'd19);
      wait_for_ciphers();

      // repeated key letter, also with a bad pair
      load_key(word_key("BALLOON"), 5'd7, 1'b0);
      send_pair(5'd0, 5'd1);
      send_pair(5'd3, 5'd3);
      wait_for_ciphers();

      // I and J in one key count as a repeat
      load_key(word_key("JIG"), 5'd3, 1'b0);
      send_pair(5'd2, 5'd5);
      wait_for_ciphers();

      load_key({125{1'b1}}, 5'd31, 1'b1);
      send_pair(5'd2, 5'd3);
      wait_for_ciphers();

      load_key(word_key("ZYXWVUTSRQPONMLKIHGFEDCBA"), 5'd25, 1'b0);
      send_pair(5'd0, 5'd25);
      send_pair(5'd14, 5'd13);
      wait_for_ciphers();

      // J in a valid key stands for I
      load_key(word_key("JUMBO"), 5'd5, 1'b0);
      send_pair(5'd8, 5'd20);
      send_pair(5'd9, 5'd12);
      wait_for_ciphers();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         calm = (ph == 5 || ph == 6);
         random_key();
         for (int n = 0; n < PAIRS_PER_PHASE; n++) random_pair();
         wait_for_ciphers();
      end
      calm = 1'b0;

      $display("Run covered %0d key settings and %0d checked pairs", keys_loaded, sb.checked);
      $display("Results with pair_error: %0d, with key_error: %0d",
               sb.pair_errors, sb.key_errors);
      if (sb.mismatches == 0 && sb.expected_ciphers.size() == 0) begin
         $display("** playfair_digraph_encrypt_top: PASSED **");
      end else begin
         $display("** playfair_digraph_encrypt_top: FAILED **");
      end
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // check results and watch for a stuck run
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_cipher(rsp_cipher_first, rsp_cipher_second, rsp_pair_error, rsp_key_error);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
            $display("** playfair_digraph_encrypt_top: FAILED **");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

endmodule
